[rtl/core/m3i_pkg.sv]
// shared widths and the cofactor operand table for the 3x3 matrix inverse core
package m3i_pkg;

	localparam int IN_W     = 16;
	localparam int IN_FRAC  = 12;
	localparam int OUT_W    = 32;
	localparam int OUT_FRAC = 16;

	localparam int N_ENT    = 9;
	localparam int PROD_W   = 2 * IN_W;
	localparam int COF_W    = PROD_W + 1;
	localparam int CMAG_W   = PROD_W;
	localparam int DP_W     = IN_W + COF_W;
	localparam int DET_W    = DP_W + 2;
	localparam int DMAG_W   = DET_W - 1;
	localparam int FRAC_SUM = IN_FRAC + OUT_FRAC;
	localparam int PRE      = OUT_W - FRAC_SUM;
	localparam int DIV_ST   = OUT_W + 1;

	typedef logic signed [IN_W-1:0]   ent_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [COF_W-1:0]  cof_t;
	typedef logic [CMAG_W-1:0]        cmag_t;
	typedef logic [DMAG_W-1:0]        dmag_t;
	typedef logic [OUT_W-1:0]         quo_t;

	// cofactor k = a[i0]*a[i1] - a[i2]*a[i3], entries indexed row*3+col
	typedef logic [3:0] eidx_t;
	localparam eidx_t COF_IDX [N_ENT][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd1, 4'd6, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd1, 4'd3}
	};

endpackage

[rtl/core/m3i_div_lane.sv]
// pipelined restoring divider lane: a load stage, then one quotient bit per stage, with overflow detect
module m3i_div_lane (
	input  logic                       clk,
	input  logic [m3i_pkg::DIV_ST-1:0] en,
	input  m3i_pkg::cmag_t             cmag,
	input  logic                       cneg,
	input  m3i_pkg::dmag_t             dmag,
	input  logic                       dneg,
	output m3i_pkg::quo_t              quo,
	output logic                       ovf,
	output logic                       neg
);
	import m3i_pkg::*;

	dmag_t          r_s   [DIV_ST];
	dmag_t          d_s   [DIV_ST];
	quo_t           q_s   [DIV_ST];
	logic [PRE-1:0] nb_s  [DIV_ST];
	logic           ovf_s [DIV_ST];
	logic           neg_s [DIV_ST];

	// load stage: quotient of 2^OUT_W or more means saturation
	always_ff @(posedge clk) begin
		if (en[0]) begin
			d_s[0]   <= dmag;
			r_s[0]   <= DMAG_W'(cmag >> PRE);
			nb_s[0]  <= cmag[PRE-1:0];
			ovf_s[0] <= (DMAG_W+PRE)'(cmag) >= {dmag, {PRE{1'b0}}};
			neg_s[0] <= cneg ^ dneg;
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k < DIV_ST; k++) begin : g_step
		logic [DMAG_W:0] r2;
		logic [DMAG_W:0] diff;
		logic            ge;
		assign r2   = {r_s[k-1], nb_s[k-1][PRE-1]};
		assign diff = r2 - {1'b0, d_s[k-1]};
		assign ge   = r2 >= {1'b0, d_s[k-1]};
		always_ff @(posedge clk) begin
			if (en[k]) begin
				r_s[k]   <= ge ? diff[DMAG_W-1:0] : r2[DMAG_W-1:0];
				q_s[k]   <= {q_s[k-1][OUT_W-2:0], ge};
				nb_s[k]  <= {nb_s[k-1][PRE-2:0], 1'b0};
				d_s[k]   <= d_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign quo = q_s[DIV_ST-1];
	assign ovf = ovf_s[DIV_ST-1];
	assign neg = neg_s[DIV_ST-1];

endmodule

[rtl/core/matrix3x3_inverse_core.sv]
// 3x3 matrix inverse by adjugate over determinant, fully pipelined
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, a_r0c0 .. a_r2c2     | request in
//  out     | out_valid, out_ready, inv_r0c0 .. inv_r2c2,| request out
//          | singular, saturated                      |
//
// pipeline order: products, cofactors and determinant, then the divider
// (one quotient bit per stage after its load stage), then saturation.
// one request per cycle sustained while out_ready holds high; each stage holds
// while the one after it is full and stalled, so bubbles close up and nothing
// is lost or repeated. reset clears only the stage valid bits.
module matrix3x3_inverse_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  m3i_pkg::ent_t         a_r0c0,
	input  m3i_pkg::ent_t         a_r0c1,
	input  m3i_pkg::ent_t         a_r0c2,
	input  m3i_pkg::ent_t         a_r1c0,
	input  m3i_pkg::ent_t         a_r1c1,
	input  m3i_pkg::ent_t         a_r1c2,
	input  m3i_pkg::ent_t         a_r2c0,
	input  m3i_pkg::ent_t         a_r2c1,
	input  m3i_pkg::ent_t         a_r2c2,
	output logic                  out_valid,
	input  logic                  out_ready,
	output m3i_pkg::quo_t         inv_r0c0,
	output m3i_pkg::quo_t         inv_r0c1,
	output m3i_pkg::quo_t         inv_r0c2,
	output m3i_pkg::quo_t         inv_r1c0,
	output m3i_pkg::quo_t         inv_r1c1,
	output m3i_pkg::quo_t         inv_r1c2,
	output m3i_pkg::quo_t         inv_r2c0,
	output m3i_pkg::quo_t         inv_r2c1,
	output m3i_pkg::quo_t         inv_r2c2,
	output logic                  singular,
	output logic                  saturated
);
	import m3i_pkg::*;

	localparam int FRONT = 5;
	localparam int NST   = FRONT + DIV_ST + 1;
	localparam int LAST  = NST - 1;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	// a stage moves when it is empty or the next one moves
	assign adv[LAST] = !vld_q[LAST] || out_ready;
	for (genvar i = 0; i < LAST; i++) begin : g_adv
		assign adv[i] = !vld_q[i] || adv[i+1];
	end
	assign in_ready  = adv[0];
	assign out_valid = vld_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	ent_t a [N_ENT];
	assign a[0] = a_r0c0;
	assign a[1] = a_r0c1;
	assign a[2] = a_r0c2;
	assign a[3] = a_r1c0;
	assign a[4] = a_r1c1;
	assign a[5] = a_r1c2;
	assign a[6] = a_r2c0;
	assign a[7] = a_r2c1;
	assign a[8] = a_r2c2;

	prod_t                   pa_s1 [N_ENT];
	prod_t                   pb_s1 [N_ENT];
	ent_t                    r0_s1 [3];
	cof_t                    cof_s2 [N_ENT];
	ent_t                    r0_s2 [3];
	logic signed [DP_W-1:0]  dp_s3 [3];
	cof_t                    cof_s3 [N_ENT];
	logic signed [DET_W-1:0] det_s4;
	cmag_t                   cmag_s4 [N_ENT];
	logic [N_ENT-1:0]        cneg_s4;
	dmag_t                   dmag_s5;
	logic                    dneg_s5;
	logic                    dz_s5;
	cmag_t                   cmag_s5 [N_ENT];
	logic [N_ENT-1:0]        cneg_s5;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int k = 0; k < N_ENT; k++) begin
				pa_s1[k] <= PROD_W'(a[COF_IDX[k][0]]) * PROD_W'(a[COF_IDX[k][1]]);
				pb_s1[k] <= PROD_W'(a[COF_IDX[k][2]]) * PROD_W'(a[COF_IDX[k][3]]);
			end
			for (int j = 0; j < 3; j++) begin
				r0_s1[j] <= a[j];
			end
		end
		if (adv[1]) begin
			for (int k = 0; k < N_ENT; k++) begin
				cof_s2[k] <= COF_W'(pa_s1[k]) - COF_W'(pb_s1[k]);
			end
			r0_s2 <= r0_s1;
		end
		// determinant expands along row 0 with adjugate column 0
		if (adv[2]) begin
			for (int j = 0; j < 3; j++) begin
				dp_s3[j] <= DP_W'(r0_s2[j]) * DP_W'(cof_s2[3*j]);
			end
			cof_s3 <= cof_s2;
		end
		if (adv[3]) begin
			det_s4 <= DET_W'(dp_s3[0]) + DET_W'(dp_s3[1]) + DET_W'(dp_s3[2]);
			for (int k = 0; k < N_ENT; k++) begin
				cneg_s4[k] <= cof_s3[k][COF_W-1];
				cmag_s4[k] <= cof_s3[k][COF_W-1] ? CMAG_W'(-cof_s3[k])
				                                 : CMAG_W'(cof_s3[k]);
			end
		end
		if (adv[4]) begin
			dneg_s5 <= det_s4[DET_W-1];
			dmag_s5 <= det_s4[DET_W-1] ? DMAG_W'(-det_s4) : DMAG_W'(det_s4);
			dz_s5   <= det_s4 == '0;
			cmag_s5 <= cmag_s4;
			cneg_s5 <= cneg_s4;
		end
	end

	quo_t             quo [N_ENT];
	logic [N_ENT-1:0] ovf;
	logic [N_ENT-1:0] neg;

	for (genvar k = 0; k < N_ENT; k++) begin : g_lane
		m3i_div_lane u_div (
			.clk  (clk),
			.en   (adv[FRONT+DIV_ST-1:FRONT]),
			.cmag (cmag_s5[k]),
			.cneg (cneg_s5[k]),
			.dmag (dmag_s5),
			.dneg (dneg_s5),
			.quo  (quo[k]),
			.ovf  (ovf[k]),
			.neg  (neg[k])
		);
	end

	// singular flag rides alongside the divider stages
	logic dz_d [DIV_ST];
	always_ff @(posedge clk) begin
		if (adv[FRONT]) begin
			dz_d[0] <= dz_s5;
		end
		for (int i = 1; i < DIV_ST; i++) begin
			if (adv[FRONT+i]) begin
				dz_d[i] <= dz_d[i-1];
			end
		end
	end

	quo_t             lim  [N_ENT];
	quo_t             mag  [N_ENT];
	quo_t             res  [N_ENT];
	logic [N_ENT-1:0] clip;

	always_comb begin
		for (int k = 0; k < N_ENT; k++) begin
			lim[k]  = neg[k] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
			clip[k] = ovf[k] || (quo[k] > lim[k]);
			mag[k]  = clip[k] ? lim[k] : quo[k];
			res[k]  = neg[k] ? -mag[k] : mag[k];
		end
	end

	quo_t inv_s39 [N_ENT];
	logic sing_s39;
	logic sat_s39;

	always_ff @(posedge clk) begin
		if (adv[LAST]) begin
			sing_s39 <= dz_d[DIV_ST-1];
			sat_s39  <= !dz_d[DIV_ST-1] && (|clip);
			for (int k = 0; k < N_ENT; k++) begin
				inv_s39[k] <= dz_d[DIV_ST-1] ? '0 : res[k];
			end
		end
	end

	assign inv_r0c0  = inv_s39[0];
	assign inv_r0c1  = inv_s39[1];
	assign inv_r0c2  = inv_s39[2];
	assign inv_r1c0  = inv_s39[3];
	assign inv_r1c1  = inv_s39[4];
	assign inv_r1c2  = inv_s39[5];
	assign inv_r2c0  = inv_s39[6];
	assign inv_r2c1  = inv_s39[7];
	assign inv_r2c2  = inv_s39[8];
	assign singular  = sing_s39;
	assign saturated = sat_s39;

endmodule
